[src/ghm_pkg.sv]
package ghm_pkg;

  localparam int BIN_COUNT  = 256;
  localparam int BIN_W      = $clog2(BIN_COUNT);
  localparam int CNT_W      = 24;
  localparam int SUM_W      = 32;
  localparam int OUT_CNT_W  = 24;
  localparam int FRAC_W     = 16;
  localparam int GRAY_W     = 8;
  localparam int CH_W       = 8;
  localparam int WSUM_W     = 13;
  localparam int DIV_W      = 24;
  localparam int DIV_LOW_W  = 16;
  localparam int DIV_STEP_W = $clog2(DIV_LOW_W + 1);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_PIXEL  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_FINISH = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [BIN_W-1:0] bin_index;
  } ghm_in_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] bin_count;
    logic [FRAC_W-1:0]    bin_fraction;
    logic [GRAY_W-1:0]    mean_gray;
    logic                 empty_flag;
    logic                 overflow_flag;
  } ghm_out_t;

  // One division job: the remainder starts below the divisor, and the low
  // bits are shifted in from the top, one per step.
  typedef struct packed {
    logic [DIV_W-1:0]      rem_init;
    logic [DIV_W-1:0]      divisor;
    logic [DIV_LOW_W-1:0]  low_bits;
    logic [DIV_STEP_W-1:0] steps;
  } ghm_div_req_t;

endpackage

[src/ghm_div.sv]
module ghm_div
  import ghm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ghm_div_req_t         req,
  output logic                 done,
  output logic [DIV_LOW_W-1:0] quot
);

  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      dvs_r;
  logic [DIV_LOW_W-1:0]  low_r;
  logic [DIV_LOW_W-1:0]  quot_r;
  logic [DIV_STEP_W-1:0] left_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic                  fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, low_r[DIV_LOW_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && left_r == DIV_STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= req.rem_init;
      dvs_r  <= req.divisor;
      low_r  <= req.low_bits;
      left_r <= req.steps;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_r  <= {low_r[DIV_LOW_W-2:0], 1'b0};
      quot_r <= {quot_r[DIV_LOW_W-2:0], fits};
      left_r <= left_r - DIV_STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[src/gray_histogram_mean_unit.sv]
// Gray-level histogram and mean unit. Each pixel word is turned into a gray
// level (11*red + 16*green + 5*blue) / 32 and counted in a 256-bin histogram
// held in a synchronous RAM with one read and one write port, next to a pixel
// total and a gray sum; all counts saturate and latch the overflow flag until
// the next clear. Pixel words are taken one per cycle while in_ready is high:
// a pixel reads its bin in the cycle it is accepted and writes the
// incremented count back in the next, and a write that has not yet landed in
// the RAM is forwarded to a following access of the same bin. A clear word
// empties the histogram at once through per-bin valid bits. Read and finish
// words each give one result word and keep in_ready low until that word sits
// in the output register. When the histogram is empty or the quotient is
// known to saturate, the word goes from ST_RD, which looks at the bin and the
// totals, straight to ST_OUT, which loads the output register. Otherwise the
// shared restoring divider runs in between, producing one quotient bit per
// cycle and then signalling completion. Loading the output register waits as
// long as an earlier result word has not been taken. A waiting result does
// not stop pixel or clear words from entering.
module gray_histogram_mean_unit
  import ghm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ghm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ghm_out_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Histogram RAM and its per-bin valid bits.
  logic [CNT_W-1:0]     hist_mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] bin_vld_r;
  logic [CNT_W-1:0]     mem_q_r;
  logic                 vld_q_r;
  logic [BIN_W-1:0]     q_idx_r;

  // Write-back stage of a pixel, and the last write for forwarding.
  logic                 s2_valid_r;
  logic                 wb_valid_r;
  logic [BIN_W-1:0]     wb_idx_r;
  logic [CNT_W-1:0]     wb_data_r;

  logic [CNT_W-1:0]     total_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 sat_r;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic                 is_fin_r;
  ghm_out_t             res_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  ghm_out_t             out_data_r;

  logic                 acc;
  logic                 clr_acc;
  logic                 pix_acc;
  logic                 rd_en;
  logic [BIN_W-1:0]     rd_addr;
  logic [WSUM_W-1:0]    wsum;
  logic [GRAY_W-1:0]    gray;
  logic                 tot_full;
  logic [SUM_W:0]       sum_add;
  logic                 sum_ovf;
  logic [CNT_W-1:0]     fwd_cnt;
  logic                 bin_full;
  logic                 s2_wr;
  logic                 empty;
  logic                 rd_sat;
  logic                 fin_sat;
  logic                 div_go;
  ghm_div_req_t         div_req;
  logic                 div_done;
  logic [DIV_LOW_W-1:0] div_quot;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign clr_acc  = acc && (in_data.req_type == REQ_CLEAR);
  assign pix_acc  = acc && (in_data.req_type == REQ_PIXEL);
  // Read and finish words both sample the RAM; a finish simply ignores it.
  assign rd_en    = acc && (in_data.req_type == REQ_PIXEL ||
                            in_data.req_type == REQ_READ ||
                            in_data.req_type == REQ_FINISH);

  // Gray level: 11r + 16g + 5b is at most 8160, so the top eight bits of a
  // 13-bit sum are the gray level.
  assign wsum = WSUM_W'(in_data.red) * WSUM_W'(11)
              + {1'b0, in_data.green, 4'b0000}
              + WSUM_W'(in_data.blue) * WSUM_W'(5);
  assign gray = wsum[WSUM_W-1:WSUM_W-GRAY_W];

  assign rd_addr = (in_data.req_type == REQ_PIXEL) ? gray : in_data.bin_index;

  assign tot_full = (total_r == CNT_MAX);
  assign sum_add  = {1'b0, sum_r} + (SUM_W+1)'(gray);
  assign sum_ovf  = sum_add[SUM_W];

  // The RAM returns the old word when it is written in the same cycle it is
  // read, so the write of the previous edge is forwarded here. A bin whose
  // valid bit is clear reads as zero.
  always_comb begin
    if (wb_valid_r && wb_idx_r == q_idx_r) begin
      fwd_cnt = wb_data_r;
    end else if (vld_q_r) begin
      fwd_cnt = mem_q_r;
    end else begin
      fwd_cnt = '0;
    end
  end

  assign bin_full = (fwd_cnt == CNT_MAX);
  assign s2_wr    = s2_valid_r && !bin_full;

  always_ff @(posedge clk) begin
    if (s2_wr) begin
      hist_mem[q_idx_r] <= fwd_cnt + CNT_W'(1);
    end
    if (rd_en) begin
      mem_q_r <= hist_mem[rd_addr];
      vld_q_r <= bin_vld_r[rd_addr];
      q_idx_r <= rd_addr;
    end
    wb_idx_r  <= q_idx_r;
    wb_data_r <= fwd_cnt + CNT_W'(1);
  end

  // A clear wins over a write-back landing in the same cycle, since the
  // pixel being written came in before the clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r  <= '0;
      s2_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
      total_r    <= '0;
      sum_r      <= '0;
      sat_r      <= 1'b0;
    end else begin
      s2_valid_r <= pix_acc && !tot_full;
      wb_valid_r <= s2_wr && !clr_acc;
      if (clr_acc) begin
        bin_vld_r <= '0;
        total_r   <= '0;
        sum_r     <= '0;
        sat_r     <= 1'b0;
      end else begin
        if (s2_wr) begin
          bin_vld_r[q_idx_r] <= 1'b1;
        end
        if (pix_acc && !tot_full) begin
          total_r <= total_r + CNT_W'(1);
          sum_r   <= sum_ovf ? SUM_MAX : sum_add[SUM_W-1:0];
        end
        if ((pix_acc && (tot_full || sum_ovf)) || (s2_valid_r && bin_full)) begin
          sat_r <= 1'b1;
        end
      end
    end
  end

  // Results. When the quotient is known to saturate, or the histogram is
  // empty, the answer is settled without the divider: count * 2^16 / total
  // reaches 2^16 exactly when count >= total, and sum / total reaches 256
  // exactly when sum / 256 >= total.
  assign empty   = (total_r == '0);
  assign rd_sat  = (fwd_cnt >= total_r);
  assign fin_sat = (sum_r[SUM_W-1:SUM_W-DIV_W] >= total_r);
  assign div_go  = (state_r == ST_RD) && !empty &&
                   (is_fin_r ? !fin_sat : !rd_sat);

  always_comb begin
    if (is_fin_r) begin
      div_req.rem_init = sum_r[SUM_W-1:SUM_W-DIV_W];
      div_req.low_bits = {sum_r[SUM_W-DIV_W-1:0], {(DIV_LOW_W-(SUM_W-DIV_W)){1'b0}}};
      div_req.steps    = DIV_STEP_W'(GRAY_W);
    end else begin
      div_req.rem_init = DIV_W'(fwd_cnt);
      div_req.low_bits = '0;
      div_req.steps    = DIV_STEP_W'(FRAC_W);
    end
    div_req.divisor = DIV_W'(total_r);
  end

  ghm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (in_data.req_type == REQ_READ || in_data.req_type == REQ_FINISH)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = div_go ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      is_fin_r <= (in_data.req_type == REQ_FINISH);
    end
    if (state_r == ST_RD) begin
      res_r.empty_flag    <= empty;
      res_r.overflow_flag <= sat_r;
      res_r.bin_count     <= is_fin_r ? '0 : OUT_CNT_W'(fwd_cnt);
      res_r.bin_fraction  <= (is_fin_r || empty) ? '0 : {FRAC_W{1'b1}};
      res_r.mean_gray     <= (!is_fin_r || empty) ? '0 : {GRAY_W{1'b1}};
    end
    if (state_r == ST_DIV && div_done) begin
      if (is_fin_r) begin
        res_r.mean_gray <= div_quot[GRAY_W-1:0];
      end else begin
        res_r.bin_fraction <= div_quot[FRAC_W-1:0];
      end
    end
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/sv/gray_histogram_mean_checker.sv]
module gray_histogram_mean_checker
  import ghm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  ghm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  ghm_out_t out_data,
  output int       fail_count,
  output int       results_owed
);

  // Shadow copy of the histogram, the pixel total, the gray sum and the
  // sticky saturation flag.
  logic [CNT_W-1:0] bin_tally [BIN_COUNT];
  logic [CNT_W-1:0] pixel_tally;
  logic [SUM_W-1:0] gray_total;
  logic             sticky_sat;

  ghm_out_t result_queue [$];
  int       errors = 0;

  task automatic empty_histogram();
    for (int i = 0; i < BIN_COUNT; i++) begin
      bin_tally[i] = '0;
    end
    pixel_tally = '0;
    gray_total  = '0;
    sticky_sat  = 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ghm_in_t           word;
    ghm_out_t          want;
    logic [12:0]       weighted;
    logic [GRAY_W-1:0] level;
    logic [SUM_W:0]    new_sum;
    logic [63:0]       share;
    logic [SUM_W-1:0]  avg;
    if (!rst_n) begin
      empty_histogram();
      result_queue.delete();
    end else begin
      // Results leave before the word accepted at this edge can add one, so
      // the oldest expectation is popped first.
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $error("result word with no read or finish word waiting");
          errors++;
        end else begin
          want = result_queue.pop_front();
          check_field("bin_count", 32'(want.bin_count), 32'(out_data.bin_count));
          check_field("bin_fraction", 32'(want.bin_fraction), 32'(out_data.bin_fraction));
          check_field("mean_gray", 32'(want.mean_gray), 32'(out_data.mean_gray));
          check_field("empty_flag", 32'(want.empty_flag), 32'(out_data.empty_flag));
          check_field("overflow_flag", 32'(want.overflow_flag),
                      32'(out_data.overflow_flag));
        end
      end
      if (in_valid && in_ready) begin
        word = in_data;
        case (word.req_type)
          REQ_CLEAR: begin
            empty_histogram();
          end
          REQ_PIXEL: begin
            weighted = 13'(11 * word.red + 16 * word.green + 5 * word.blue);
            level    = weighted[12:5];
            if (pixel_tally == '1) begin
              // A full total drops the pixel altogether.
              sticky_sat = 1'b1;
            end else begin
              pixel_tally++;
              if (bin_tally[level] == '1) begin
                sticky_sat = 1'b1;
              end else begin
                bin_tally[level]++;
              end
              new_sum = {1'b0, gray_total} + (SUM_W+1)'(level);
              if (new_sum[SUM_W]) begin
                gray_total = '1;
                sticky_sat = 1'b1;
              end else begin
                gray_total = new_sum[SUM_W-1:0];
              end
            end
          end
          default: begin
            want               = '0;
            want.empty_flag    = (pixel_tally == '0);
            want.overflow_flag = sticky_sat;
            if (word.req_type == REQ_READ) begin
              want.bin_count = bin_tally[word.bin_index];
              if (pixel_tally != '0) begin
                share = (64'(bin_tally[word.bin_index]) << FRAC_W) / 64'(pixel_tally);
                want.bin_fraction = (share > 64'hFFFF) ? '1 : share[FRAC_W-1:0];
              end
            end else if (pixel_tally != '0) begin
              avg = gray_total / SUM_W'(pixel_tally);
              want.mean_gray = (avg > 255) ? '1 : avg[GRAY_W-1:0];
            end
            result_queue.push_back(want);
          end
        endcase
      end
    end
    fail_count   <= errors;
    results_owed <= result_queue.size();
  end

endmodule

[tb/sv/tb_gray_histogram_mean_unit.sv]
module tb_gray_histogram_mean_unit
  import ghm_pkg::*;
();

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ghm_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ghm_out_t out_data;

  // Reported by the checker: mismatches so far, and result words it still
  // expects to see.
  int fail_count;
  int results_owed;

  // Largest idle gap each side may draw per word. The stimulus changes these
  // every few dozen words so that runs with no idling alternate with light
  // and heavy idling on both channels.
  int tx_gap_max;
  int rx_gap_max;

  gray_histogram_mean_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The checker watches both channels, keeps its own histogram and compares
  // every result word with the oldest expectation.
  gray_histogram_mean_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The slowest correct run is well under half a million time units, even
  // with every word waiting out the longest gaps and the longest division.
  initial begin
    #2000000;
    $display("tb_gray_histogram_mean_unit failed");
    $finish;
  end

  function automatic ghm_in_t make_word(input logic [1:0] req, input logic [CH_W-1:0] r,
                                        input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                                        input logic [BIN_W-1:0] idx);
    ghm_in_t word;
    word.req_type  = req;
    word.red       = r;
    word.green     = g;
    word.blue      = b;
    word.bin_index = idx;
    return word;
  endfunction

  // Channel values lean toward the extremes, which give the corner gray
  // levels, but most are uniform over the whole range.
  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CH_W-1:0] rand_byte();
    return CH_W'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 14;
    endcase
  endfunction

  // Presents one word after a random idle gap and returns at the edge where
  // it is accepted. Valid is left high so that a following word with no gap
  // goes out back to back; only a real gap lowers it.
  task automatic send_word(input ghm_in_t word);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= word;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result side: after each accepted result word, ready is held low for a
  // freshly drawn number of cycles and then raised until the next word goes.
  initial begin : result_sink
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        stall_left = $urandom_range(0, rx_gap_max);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    ghm_in_t          word;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [BIN_W-1:0] last_level;
    int               roll;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    tx_gap_max = 0;
    rx_gap_max = 0;
    last_level = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, sent back to back. An empty histogram must report the
    // empty flag with a zero fraction and a zero mean.
    send_word(make_word(REQ_FINISH, 8'hA5, 8'h5A, 8'hFF, 8'h81));
    send_word(make_word(REQ_READ, 8'hFF, 8'h00, 8'h3C, 8'h00));
    // Gray levels 0 and 255, the latter twice in a row so that the second
    // increment has to see the first before it reaches the RAM; the read
    // right after checks forwarding too.
    send_word(make_word(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_word(make_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_word(make_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h55));
    send_word(make_word(REQ_READ, 8'h00, 8'hFF, 8'h00, 8'hFF));
    // One primary at a time, full scale.
    send_word(make_word(REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'hAA));
    send_word(make_word(REQ_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h0F));
    send_word(make_word(REQ_PIXEL, 8'h00, 8'h00, 8'hFF, 8'hF0));
    send_word(make_word(REQ_READ, 8'h12, 8'h34, 8'h56, 8'd87));
    send_word(make_word(REQ_READ, 8'hFF, 8'hFF, 8'hFF, 8'd0));
    send_word(make_word(REQ_READ, 8'h00, 8'h00, 8'h00, 8'd200));
    send_word(make_word(REQ_FINISH, 8'h00, 8'h00, 8'h00, 8'h00));
    // A bin that holds every pixel has a share of exactly one, which must
    // saturate the fraction; the mean is then the top gray level.
    send_word(make_word(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_word(make_word(REQ_READ, 8'h00, 8'h00, 8'h00, 8'd255));
    send_word(make_word(REQ_FINISH, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // After a clear everything must look empty again.
    send_word(make_word(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_word(REQ_READ, 8'h00, 8'h00, 8'h00, 8'd255));
    send_word(make_word(REQ_FINISH, 8'h00, 8'h00, 8'h00, 8'h00));

    // Random part. Pixels dominate so that the histogram fills up between
    // the rare clears; reads mostly target the bin of the latest pixel so
    // that they see nonzero counts and hit recently written bins.
    for (int n = 0; n < 1750; n++) begin
      if (n % 64 == 0) begin
        tx_gap_max = pick_gap_max();
        rx_gap_max = pick_gap_max();
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        word = make_word(REQ_CLEAR, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end else if (roll < 73) begin
        r = pick_channel();
        g = pick_channel();
        b = pick_channel();
        last_level = BIN_W'((11 * r + 16 * g + 5 * b) >> 5);
        word = make_word(REQ_PIXEL, r, g, b, rand_byte());
      end else if (roll < 93) begin
        word = make_word(REQ_READ, rand_byte(), rand_byte(), rand_byte(),
                         ($urandom_range(0, 9) < 6) ? last_level : BIN_W'(rand_byte()));
      end else begin
        word = make_word(REQ_FINISH, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end
      send_word(word);
    end
    in_valid <= 1'b0;

    // One edge lets the checker count the last accepted word; then wait for
    // every expected result, and a little longer to catch stray ones.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_gray_histogram_mean_unit passed");
    end else begin
      $display("tb_gray_histogram_mean_unit failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ghm_pkg.sv
src/ghm_div.sv
src/gray_histogram_mean_unit.sv
tb/sv/gray_histogram_mean_checker.sv
tb/sv/tb_gray_histogram_mean_unit.sv
